>>> sv/spm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the sample player mixer
// Sizes, opcodes, command codes and the word that goes from front to back.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int SAMPLE_DEPTH     = 4096;
	localparam int VOICE_COUNT      = 3;
	localparam int REQUEST_INTERVAL = 500;
	localparam int LENGTH_REGS      = 3;
	localparam int QDEPTH           = 4;

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int LW  = $clog2(SAMPLE_DEPTH + 1);
	localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int TW  = (REQUEST_INTERVAL > 1) ? $clog2(REQUEST_INTERVAL) : 1;
	localparam int CW  = 13;
	localparam int PAW = $clog2(4 * LENGTH_REGS);
	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_CMD   = 2'd1;
	localparam logic [1:0] OP_VOL   = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic [7:0] CMD_ONESHOT    = 8'h70;
	localparam logic [7:0] CMD_VOICE_BASE = 8'h31;

	localparam logic [11:0]   GAIN_RESET   = 12'd2048;
	localparam logic [CW-1:0] LENGTH_RESET = 13'd4096;

	typedef enum logic [2:0] {
		K_TICK,
		K_TOGGLE,
		K_ONESHOT,
		K_GAIN,
		K_WRITE
	} spm_kind_t;

	typedef struct packed {
		spm_kind_t      kind;
		logic [VW-1:0]  voice;
		logic [AW-1:0]  addr;
		logic [11:0]    data;
	} spm_op_t;

	typedef struct packed {
		logic    valid;
		spm_op_t op;
	} spm_q_t;

	// length register as played: zero acts as one, clamp to the store depth
	function automatic logic [LW-1:0] eff_len(input logic [CW-1:0] r);
		if (r == '0) begin
			eff_len = LW'(1);
		end else if (int'(r) > SAMPLE_DEPTH) begin
			eff_len = LW'(SAMPLE_DEPTH);
		end else begin
			eff_len = LW'(r);
		end
	endfunction

endpackage
`default_nettype wire

>>> sv/spm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_in_if: input channel of the sample player mixer
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface spm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  command_byte;
	logic [11:0] volume_value;
	logic [1:0]  voice;
	logic [11:0] sample_address;
	logic [7:0]  sample_byte;

	modport source (
		output valid, opcode, command_byte, volume_value, voice, sample_address,
			sample_byte,
		input ready
	);
	modport sink (
		input valid, opcode, command_byte, volume_value, voice, sample_address,
			sample_byte,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/spm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_out_if: output channel of the sample player mixer
// Valid/ready channel carrying one mixed output word.
// ----------------------------------------------------------------------------
interface spm_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] dac_value;
	logic       volume_request;
	logic       one_shot_flag;

	modport source (
		output valid, dac_value, volume_request, one_shot_flag,
		input ready
	);
	modport sink (
		input valid, dac_value, volume_request, one_shot_flag,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/sample_player_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_player_mixer: three-voice sample playback mixer
// Register port for voice lengths, decode front end, queue, playback back end.
// ----------------------------------------------------------------------------
// Every input word is accepted while the queue has room, so words may follow
// back to back. Commands, gain updates and sample writes act as they leave the
// queue; a tick leaves it the same way and its output word is formed through
// the voice memory read, gain multiply, and mix and clamp registers, the
// stages overlapping with later words and holding while the output is
// stalled. The back end pops one word per cycle while the output is not
// stalled. Only ticks give an output word. Voice memories are not cleared at
// reset: play only samples that were written. Change the length registers
// only while the block is idle.
// ----------------------------------------------------------------------------
module sample_player_mixer import spm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [PAW-1:0]  paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	spm_in_if.sink          item,
	spm_out_if.source       result
);

	logic [CW-1:0]     len_q [LENGTH_REGS];
	logic [PAW-3:0]    idx;
	logic              wr;
	spm_q_t            push;
	spm_q_t            head;
	logic              q_full;
	logic              pop;

	assign pready = 1'b1;
	assign idx    = paddr[PAW-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LENGTH_REGS; i++) begin
				len_q[i] <= LENGTH_RESET;
			end
		end else if (wr) begin
			for (int i = 0; i < LENGTH_REGS; i++) begin
				if (int'(idx) == i) begin
					len_q[i] <= pwdata[CW-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < LENGTH_REGS; i++) begin
			if (int'(idx) == i) begin
				prdata = 32'(len_q[i]);
			end
		end
	end

	spm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (push)
	);

	spm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	spm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.length_regs (len_q),
		.result      (result)
	);

	// DAC word is an 8-bit level shifted up by two
	a_dac_align: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.dac_value[1:0] == 2'b00)
		else $error("dac word not aligned");

	// a pop always leaves room in the queue
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !q_full)
		else $error("queue still full after pop");

	// input stalls only because the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> q_full)
		else $error("input stalled with queue space");

endmodule
`default_nettype wire

>>> sv/spm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_front: input decode
// Takes input words, decodes them into operations and drops the ones that
// have no effect, then hands them to the queue.
// ----------------------------------------------------------------------------
module spm_front import spm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	spm_in_if.sink item,
	input  logic   q_full,
	output spm_q_t push
);

	logic    vld_s1;
	spm_op_t op_s1;
	spm_op_t op_c;
	logic    keep_c;
	logic    acc;

	assign item.ready = !vld_s1 || !q_full;
	assign acc        = item.valid && item.ready;

	always_comb begin
		op_c   = '0;
		keep_c = 1'b0;
		unique case (item.opcode)
			OP_TICK: begin
				op_c.kind = K_TICK;
				keep_c    = 1'b1;
			end
			OP_CMD: begin
				if (item.command_byte == CMD_ONESHOT) begin
					op_c.kind = K_ONESHOT;
					keep_c    = 1'b1;
				end else if (item.command_byte >= CMD_VOICE_BASE &&
						int'(item.command_byte - CMD_VOICE_BASE) < VOICE_COUNT) begin
					op_c.kind  = K_TOGGLE;
					op_c.voice = VW'(item.command_byte - CMD_VOICE_BASE);
					keep_c     = 1'b1;
				end
			end
			OP_VOL: begin
				op_c.kind = K_GAIN;
				op_c.data = item.volume_value;
				keep_c    = 1'b1;
			end
			OP_WRITE: begin
				// out-of-range voice or address: dropped
				if (int'(item.voice) < VOICE_COUNT &&
						int'(item.sample_address) < SAMPLE_DEPTH) begin
					op_c.kind  = K_WRITE;
					op_c.voice = VW'(item.voice);
					op_c.addr  = AW'(item.sample_address);
					op_c.data  = {4'b0000, item.sample_byte};
					keep_c     = 1'b1;
				end
			end
			default: begin
				keep_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= acc && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= op_c;
		end
	end

	assign push.valid = vld_s1 && !q_full;
	assign push.op    = op_s1;

endmodule
`default_nettype wire

>>> sv/spm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_fifo: operation queue
// Short register queue between decode and playback.
// ----------------------------------------------------------------------------
module spm_fifo import spm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  spm_q_t push,
	output logic   full,
	input  logic   pop,
	output spm_q_t head
);

	spm_op_t        mem_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full       = cnt_q == QCW'(QDEPTH);
	assign head.valid = cnt_q != '0;
	assign head.op    = mem_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.op;
		end
	end

endmodule
`default_nettype wire

>>> sv/spm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spm_back: playback and mix
// Executes queued operations in order; a tick reads every voice memory,
// scales by the gain and mixes into one output word.
// ----------------------------------------------------------------------------
module spm_back import spm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  spm_q_t          head,
	output logic            pop,
	input  logic [CW-1:0]   length_regs [LENGTH_REGS],
	spm_out_if.source       result
);

	localparam int SW = 11 + $clog2(VOICE_COUNT + 1);

	logic adv;
	logic tick_c;
	logic wr_c;

	logic [VOICE_COUNT-1:0] on_q;
	logic [AW-1:0]          pos_q [VOICE_COUNT];
	logic                   one_shot_q;
	logic [11:0]            gain_q;
	logic [TW-1:0]          tcnt_q;
	logic [TW:0]            tnext_c;
	logic                   req_c;

	logic [LW-1:0]          len_c  [VOICE_COUNT];
	logic [LW-1:0]          nxt_c  [VOICE_COUNT];
	logic signed [9:0]      part_c [VOICE_COUNT];

	// stage 1: memory read data
	logic                   vld_s1;
	logic [VOICE_COUNT-1:0] act_s1;
	logic [11:0]            gain_s1;
	logic                   os_s1;
	logic                   req_s1;

	// stage 2: scaled contributions
	logic                   vld_s2;
	logic signed [9:0]      part_s2 [VOICE_COUNT];
	logic                   multi_s2;
	logic                   os_s2;
	logic                   req_s2;

	logic                   out_vld_q;
	logic [9:0]             dac_q;
	logic                   req_q;
	logic                   os_q;

	logic signed [SW-1:0]   sum_c;
	logic signed [SW-1:0]   half_c;
	logic signed [SW-1:0]   off_c;
	logic [7:0]             byte_c;

	assign adv    = !out_vld_q || result.ready;
	assign pop    = head.valid && adv;
	assign tick_c = pop && head.op.kind == K_TICK;
	assign wr_c   = pop && head.op.kind == K_WRITE;

	assign tnext_c = {1'b0, tcnt_q} + (TW+1)'(1);
	assign req_c   = tnext_c >= (TW+1)'(REQUEST_INTERVAL);

	for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
		logic [7:0]        mem [SAMPLE_DEPTH];
		logic [7:0]        smp_s1;
		logic signed [8:0] s_c;
		logic signed [21:0] prod_c;

		if (v < LENGTH_REGS) begin : g_reg
			assign len_c[v] = eff_len(length_regs[v]);
		end else begin : g_fix
			assign len_c[v] = LW'(SAMPLE_DEPTH);
		end

		assign nxt_c[v] = LW'(pos_q[v]) + LW'(1);

		always_ff @(posedge clk) begin
			if (wr_c && head.op.voice == VW'(v)) begin
				mem[head.op.addr] <= head.op.data[7:0];
			end
			if (tick_c) begin
				smp_s1 <= mem[pos_q[v]];
			end
		end

		// floor((sample - 128) * gain / 4096): arithmetic shift of the product
		assign s_c       = $signed({1'b0, smp_s1}) - 9'sd128;
		assign prod_c    = s_c * $signed({1'b0, gain_s1});
		assign part_c[v] = act_s1[v] ? prod_c[21:12] : 10'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q       <= '0;
			one_shot_q <= 1'b0;
			gain_q     <= GAIN_RESET;
			tcnt_q     <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				pos_q[v] <= '0;
			end
		end else if (pop) begin
			if (head.op.kind == K_ONESHOT) begin
				one_shot_q <= !one_shot_q;
			end
			if (head.op.kind == K_GAIN) begin
				gain_q <= head.op.data;
			end
			if (head.op.kind == K_TICK) begin
				tcnt_q <= req_c ? '0 : tnext_c[TW-1:0];
			end
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (head.op.kind == K_TOGGLE && head.op.voice == VW'(v)) begin
					on_q[v] <= !on_q[v];
					if (!on_q[v]) begin
						pos_q[v] <= '0;
					end
				end else if (head.op.kind == K_TICK && on_q[v]) begin
					if (nxt_c[v] >= len_c[v]) begin
						pos_q[v] <= '0;
						if (one_shot_q) begin
							on_q[v] <= 1'b0;
						end
					end else begin
						pos_q[v] <= AW'(nxt_c[v]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= tick_c;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_c) begin
			act_s1  <= on_q;
			gain_s1 <= gain_q;
			os_s1   <= one_shot_q;
			req_s1  <= req_c;
		end
		if (adv) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				part_s2[v] <= part_c[v];
			end
			multi_s2 <= $countones(act_s1) > 1;
			os_s2    <= os_s1;
			req_s2   <= req_s1;
			dac_q    <= {byte_c, 2'b00};
			req_q    <= req_s2;
			os_q     <= os_s2;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			sum_c = sum_c + SW'(part_s2[v]);
		end
		half_c = multi_s2 ? (sum_c >>> 1) : sum_c;
		off_c  = half_c + SW'(128);
		if (off_c < 0) begin
			byte_c = 8'd0;
		end else if (off_c > 255) begin
			byte_c = 8'd255;
		end else begin
			byte_c = off_c[7:0];
		end
	end

	assign result.valid          = out_vld_q;
	assign result.dac_value      = dac_q;
	assign result.volume_request = req_q;
	assign result.one_shot_flag  = os_q;

endmodule
`default_nettype wire
